FILE: src/meab_pkg.sv
package meab_pkg;

  // Field widths of the words on the two channels.
  localparam int FUNC_W    = 2;
  localparam int VERT_W    = 10;
  localparam int SLOT_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 4;

  // Default sizes of the adjacency table.
  localparam int NUM_VERTS_DEF     = 1024;
  localparam int MAX_NEIGHBORS_DEF = 8;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  // Write strobes from the sequencer to the list storage.
  typedef struct packed {
    logic cnt_we;
    logic nbr_we;
  } meab_wr_t;

endpackage

FILE: src/meab_if.sv
interface meab_in_if import meab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [VERT_W-1:0] vert_a;
  logic [VERT_W-1:0] vert_b;
  logic [VERT_W-1:0] vert_c;
  logic [SLOT_W-1:0] read_slot;

  modport source (output valid, func, vert_a, vert_b, vert_c, read_slot, input ready);
  modport sink   (input valid, func, vert_a, vert_b, vert_c, read_slot, output ready);
endinterface

interface meab_out_if import meab_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [VERT_W-1:0]    neighbor;
  logic [CNT_OUT_W-1:0] neighbor_count;

  modport source (output valid, status, neighbor, neighbor_count, input ready);
  modport sink   (input valid, status, neighbor, neighbor_count, output ready);
endinterface

FILE: src/meab_lists.sv
module meab_lists import meab_pkg::*; #(
  parameter int NUM_VERTS     = NUM_VERTS_DEF,
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  logic                                         clk_i,
  input  meab_wr_t                                     wr_i,
  input  logic [$clog2(NUM_VERTS)-1:0]                 cnt_addr_i,
  input  logic [$clog2(MAX_NEIGHBORS+1)-1:0]           cnt_wdata_i,
  input  logic [$clog2(NUM_VERTS)+$clog2(MAX_NEIGHBORS)-1:0] nbr_addr_i,
  input  logic [VERT_W-1:0]                            nbr_wdata_i,
  output logic [$clog2(MAX_NEIGHBORS+1)-1:0]           cnt_rdata_o,
  output logic [VERT_W-1:0]                            nbr_rdata_o
);

  localparam int SW       = $clog2(MAX_NEIGHBORS);
  localparam int CW       = $clog2(MAX_NEIGHBORS + 1);
  localparam int NbrDepth = NUM_VERTS * (2 ** SW);

  // One row of slots per vertex, the row padded to a power of two.
  logic [CW-1:0]     cnt_mem_q [NUM_VERTS];
  logic [VERT_W-1:0] nbr_mem_q [NbrDepth];
  logic [CW-1:0]     cnt_rdata_q;
  logic [VERT_W-1:0] nbr_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt_we) begin
      cnt_mem_q[cnt_addr_i] <= cnt_wdata_i;
    end
    cnt_rdata_q <= cnt_mem_q[cnt_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.nbr_we) begin
      nbr_mem_q[nbr_addr_i] <= nbr_wdata_i;
    end
    nbr_rdata_q <= nbr_mem_q[nbr_addr_i];
  end

  assign cnt_rdata_o = cnt_rdata_q;
  assign nbr_rdata_o = nbr_rdata_q;

endmodule

FILE: src/mesh_edge_adjacency_builder.sv
// Unique-edge table for a triangle mesh. Each vertex holds a count and a list of
// neighbours with indices no smaller than its own. Words arrive on in_i and one
// result word per input word leaves on out_o; both channels move a word when
// valid and ready are high at a rising clock edge.
// An add word files edges (a,b), (a,c) and (b,c) under their smaller endpoint,
// appending each only when a scan of that list does not already hold it. The
// scan uses a single compare unit, one slot per cycle, under a small sequencer.
// For each edge the sequencer reads the owner's count, then scans its list slot
// by slot until a hit or the end of the list; a clear walks every count entry
// once, and every word ends by reading the count and slot for its result.
// One word is in work at a time; in_i.ready is high only when idle, so the block
// takes no new word before it is done with the last one. After reset the block
// zeroes every count entry before it raises in_i.ready. A finished result waits
// in the output register while the next word is accepted; should the receiver
// still stall when that word is done, the sequencer holds it until the register
// empties.
module mesh_edge_adjacency_builder import meab_pkg::*; #(
  parameter int NUM_VERTS     = NUM_VERTS_DEF,
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  meab_in_if.sink     in_i,
  meab_out_if.source  out_o
);

  localparam int VW  = $clog2(NUM_VERTS);
  localparam int SW  = $clog2(MAX_NEIGHBORS);
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int NAW = VW + SW;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SWEEP     = 3'd1;
  localparam logic [2:0] ST_EDGE_CNT  = 3'd2;
  localparam logic [2:0] ST_EDGE_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN_ISSUE = 3'd4;
  localparam logic [2:0] ST_FIN_WAIT  = 3'd5;

  localparam logic [1:0] EDGE_LAST = 2'd2;

  function automatic logic [VW-1:0] to_vidx(input logic [VERT_W-1:0] v);
    logic [VW+VERT_W-1:0] ext;
    ext = {{VW{1'b0}}, v};
    return ext[VW-1:0];
  endfunction

  function automatic logic [SW-1:0] to_slot(input logic [CW-1:0] s);
    logic [SW+CW-1:0] ext;
    ext = {{SW{1'b0}}, s};
    return ext[SW-1:0];
  endfunction

  function automatic logic in_range(input logic [VERT_W-1:0] v);
    return 32'(v) < NUM_VERTS;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [VERT_W-1:0]    a_q, a_d, b_q, b_d, c_q, c_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [1:0]           edge_q, edge_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [STAT_W-1:0]    status_q, status_d;
  logic [VW-1:0]        ptr_q, ptr_d;
  logic                 sweep_res_q, sweep_res_d;

  logic                 out_valid_q, out_valid_d;
  logic [STAT_W-1:0]    out_status_q, out_status_d;
  logic [VERT_W-1:0]    out_nb_q, out_nb_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;

  meab_wr_t             wr;
  logic [VW-1:0]        cnt_addr;
  logic [CW-1:0]        cnt_wdata;
  logic [NAW-1:0]       nbr_addr;
  logic [CW-1:0]        cnt_rdata;
  logic [VERT_W-1:0]    nbr_rdata;

  logic [VERT_W-1:0]    edge_x, edge_y, owner, other;
  logic [CW-1:0]        scan_idx;
  logic                 a_ok;
  logic [CNT_OUT_W+CW-1:0] cnt_ext;

  meab_lists #(
    .NUM_VERTS     (NUM_VERTS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_lists (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .cnt_addr_i  (cnt_addr),
    .cnt_wdata_i (cnt_wdata),
    .nbr_addr_i  (nbr_addr),
    .nbr_wdata_i (other),
    .cnt_rdata_o (cnt_rdata),
    .nbr_rdata_o (nbr_rdata)
  );

  // Endpoints of the edge in hand, and the vertex it is filed under.
  always_comb begin
    case (edge_q)
      2'd0:    begin edge_x = a_q; edge_y = b_q; end
      2'd1:    begin edge_x = a_q; edge_y = c_q; end
      default: begin edge_x = b_q; edge_y = c_q; end
    endcase
    owner = (edge_y > edge_x) ? edge_x : edge_y;
    other = (edge_y > edge_x) ? edge_y : edge_x;
  end

  // While scanning, the slot one ahead is fetched so that its data is ready
  // in the cycle the index reaches it.
  assign scan_idx = (state_q == ST_EDGE_SCAN) ? idx_q + CW'(1) : idx_q;
  assign a_ok     = in_range(a_q);
  assign cnt_ext  = {{CNT_OUT_W{1'b0}}, (a_ok ? cnt_rdata : CW'(0))};

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    a_d          = a_q;
    b_d          = b_q;
    c_d          = c_q;
    slot_d       = slot_q;
    edge_d       = edge_q;
    idx_d        = idx_q;
    status_d     = status_q;
    ptr_d        = ptr_q;
    sweep_res_d  = sweep_res_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_nb_d     = out_nb_q;
    out_cnt_d    = out_cnt_q;

    wr        = '0;
    cnt_addr  = to_vidx(owner);
    cnt_wdata = cnt_rdata + CW'(1);
    nbr_addr  = {to_vidx(owner), to_slot(scan_idx)};

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          func_d   = in_i.func;
          a_d      = in_i.vert_a;
          b_d      = in_i.vert_b;
          c_d      = in_i.vert_c;
          slot_d   = in_i.read_slot;
          edge_d   = 2'd0;
          idx_d    = '0;
          status_d = STAT_OK;
          case (in_i.func)
            FUNC_CLEAR: begin
              ptr_d       = '0;
              sweep_res_d = 1'b1;
              state_d     = ST_SWEEP;
            end
            FUNC_ADD: begin
              if (in_range(in_i.vert_a) && in_range(in_i.vert_b) &&
                  in_range(in_i.vert_c)) begin
                state_d = ST_EDGE_CNT;
              end else begin
                status_d = STAT_OVERFLOW;
                state_d  = ST_FIN_ISSUE;
              end
            end
            default: begin
              state_d = ST_FIN_ISSUE;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        wr.cnt_we = 1'b1;
        cnt_addr  = ptr_q;
        cnt_wdata = '0;
        if (ptr_q == VW'(NUM_VERTS - 1)) begin
          state_d = sweep_res_q ? ST_FIN_ISSUE : ST_IDLE;
        end else begin
          ptr_d = ptr_q + VW'(1);
        end
      end

      ST_EDGE_CNT: begin
        state_d = ST_EDGE_SCAN;
      end

      ST_EDGE_SCAN: begin
        if (idx_q >= cnt_rdata) begin
          // Not in the list: append, or give up when the list is full.
          if (cnt_rdata >= CW'(MAX_NEIGHBORS)) begin
            status_d = STAT_OVERFLOW;
            state_d  = ST_FIN_ISSUE;
          end else begin
            wr.cnt_we = 1'b1;
            wr.nbr_we = 1'b1;
            nbr_addr  = {to_vidx(owner), to_slot(cnt_rdata)};
            idx_d     = '0;
            if (edge_q == EDGE_LAST) begin
              state_d = ST_FIN_ISSUE;
            end else begin
              edge_d  = edge_q + 2'd1;
              state_d = ST_EDGE_CNT;
            end
          end
        end else if (nbr_rdata == other) begin
          idx_d = '0;
          if (edge_q == EDGE_LAST) begin
            state_d = ST_FIN_ISSUE;
          end else begin
            edge_d  = edge_q + 2'd1;
            state_d = ST_EDGE_CNT;
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      ST_FIN_ISSUE, ST_FIN_WAIT: begin
        cnt_addr = to_vidx(a_q);
        nbr_addr = {to_vidx(a_q), to_slot(CW'(slot_q))};
        if (state_q == ST_FIN_ISSUE) begin
          state_d = ST_FIN_WAIT;
        end else if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_ext[CNT_OUT_W-1:0];
          out_nb_d    = '0;
          out_status_d = status_q;
          if (func_q == FUNC_READ) begin
            if (!a_ok || (32'(slot_q) >= 32'(cnt_rdata))) begin
              out_status_d = STAT_EMPTY;
            end else begin
              out_nb_d = nbr_rdata;
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      ptr_q       <= '0;
      sweep_res_q <= 1'b0;
      out_valid_q <= 1'b0;
      edge_q      <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      sweep_res_q <= sweep_res_d;
      out_valid_q <= out_valid_d;
      edge_q      <= edge_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    a_q          <= a_d;
    b_q          <= b_d;
    c_q          <= c_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_nb_q     <= out_nb_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.neighbor       = out_nb_q;
  assign out_o.neighbor_count = out_cnt_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

// Testbench for the mesh edge adjacency builder.
// Words are sent on the input channel and the edge table is predicted alongside
// the block. Each accepted input word yields exactly one result word, so the
// predicted replies are kept in a queue in acceptance order. A separate process
// checks every result word against the oldest reply in that queue.
module tb;
  import meab_pkg::*;

  // The package stops at the three real operations; the fourth code is unused.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // A clear walks every count entry, so it is by far the slowest word.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLDOFF_CYCLES = 150;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;
    logic [VERT_W-1:0] c;
    logic [SLOT_W-1:0] slot;
  } tri_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [VERT_W-1:0]    neighbor;
    logic [CNT_OUT_W-1:0] count;
  } table_reply_t;

  logic clk_i;
  logic rst_ni;

  meab_in_if  in_if ();
  meab_out_if out_if ();

  mesh_edge_adjacency_builder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Our own copy of the edge table: a count per vertex and its neighbour list.
  logic [CNT_OUT_W-1:0] adj_len [NUM_VERTS_DEF];
  logic [VERT_W-1:0]    adj_nbr [NUM_VERTS_DEF][MAX_NEIGHBORS_DEF];

  // Replies the block still owes us, oldest first.
  table_reply_t table_replies [$];

  int unsigned mismatches;
  int unsigned cycle_count;

  // Percentages of cycles in which each side idles.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  // A request for the receiver to hold off; the receiver counts it down itself.
  int unsigned hold_req;

  // The random part works on a small window of vertices at a time, so that
  // lists fill up, edges repeat and overflow is reached often.
  int unsigned pool_base;
  int unsigned pool_life;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Files the edge (x,y) under its smaller endpoint. Returns 1 when the edge is
  // new and the owning list is already full; an edge already present is a hit
  // even in a full list.
  function automatic bit place_edge(input logic [VERT_W-1:0] x,
                                    input logic [VERT_W-1:0] y);
    logic [VERT_W-1:0] owner;
    logic [VERT_W-1:0] other;
    int unsigned       n;
    owner = (y > x) ? x : y;
    other = (y > x) ? y : x;
    n     = adj_len[owner];
    for (int i = 0; i < n; i++) begin
      if (adj_nbr[owner][i] == other) return 1'b0;
    end
    if (n >= MAX_NEIGHBORS_DEF) return 1'b1;
    adj_nbr[owner][n] = other;
    adj_len[owner]    = CNT_OUT_W'(n + 1);
    return 1'b0;
  endfunction

  // Applies one word to the predicted table and returns the reply it earns.
  // With ten-bit indices and a table of 1024 vertices no index is ever out of
  // range, so that case cannot arise here.
  function automatic table_reply_t edge_table_apply(input tri_word_t w);
    table_reply_t r;
    r = '0;
    case (w.func)
      FUNC_CLEAR: begin
        foreach (adj_len[v]) adj_len[v] = '0;
      end
      FUNC_ADD: begin
        // The edges are tried in order and the first overflow skips the rest.
        if (place_edge(w.a, w.b) || place_edge(w.a, w.c) || place_edge(w.b, w.c))
          r.status = STAT_OVERFLOW;
      end
      FUNC_READ: begin
        if (w.slot >= adj_len[w.a]) r.status = STAT_EMPTY;
        else r.neighbor = adj_nbr[w.a][w.slot];
      end
      default: begin
        // The unused code leaves the table alone and reports a plain count.
      end
    endcase
    r.count = adj_len[w.a];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one word and waits until it is taken. Valid is only lowered when an
  // idle cycle is chosen, so back-to-back words keep it high throughout.
  task automatic send_word(input tri_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= w.func;
    in_if.vert_a    <= w.a;
    in_if.vert_b    <= w.b;
    in_if.vert_c    <= w.c;
    in_if.read_slot <= w.slot;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    table_replies.push_back(edge_table_apply(w));
  endtask

  // Stops offering words and waits for every owed reply to arrive.
  task automatic drain_replies();
    in_if.valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic tri_word_t make_word(input logic [FUNC_W-1:0] func,
                                          input int unsigned a,
                                          input int unsigned b,
                                          input int unsigned c,
                                          input int unsigned slot);
    tri_word_t w;
    w.func = func;
    w.a    = VERT_W'(a);
    w.b    = VERT_W'(b);
    w.c    = VERT_W'(c);
    w.slot = SLOT_W'(slot);
    return w;
  endfunction

  // Mostly a vertex from the current window, now and then any vertex at all.
  function automatic logic [VERT_W-1:0] pool_vertex();
    if ($urandom_range(9) == 0) return VERT_W'($urandom_range(NUM_VERTS_DEF - 1));
    return VERT_W'(pool_base + $urandom_range(15));
  endfunction

  function automatic tri_word_t random_mesh_word();
    tri_word_t   w;
    int unsigned pick;
    if (pool_life == 0) begin
      pool_base = $urandom_range(NUM_VERTS_DEF - 16);
      pool_life = $urandom_range(80, 30);
    end
    pool_life--;
    pick   = $urandom_range(999);
    w.a    = pool_vertex();
    w.b    = pool_vertex();
    w.c    = pool_vertex();
    w.slot = SLOT_W'($urandom_range(MAX_NEIGHBORS_DEF - 1));
    if (pick < 8) begin
      w.func = FUNC_CLEAR;
    end else if (pick < 25) begin
      w.func = FUNC_UNUSED;
    end else if (pick < 600) begin
      w.func = FUNC_ADD;
      // Triangles with repeated corners give edges from a vertex to itself.
      if ($urandom_range(9) == 0) w.b = w.a;
      if ($urandom_range(9) == 0) w.c = w.b;
    end else begin
      w.func = FUNC_READ;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver either serves a requested hold-off or stalls at random.
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Every result word is matched against the oldest reply still owed.
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (table_replies.size() == 0) begin
        $error("result word with no reply owed: status %0d neighbor %0d count %0d",
               out_if.status, out_if.neighbor, out_if.neighbor_count);
        mismatches++;
      end else begin
        want = table_replies.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.neighbor !== want.neighbor) begin
          $error("neighbor: expected %0d, got %0d", want.neighbor, out_if.neighbor);
          mismatches++;
        end
        if (out_if.neighbor_count !== want.count) begin
          $error("neighbor_count: expected %0d, got %0d", want.count,
                 out_if.neighbor_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog. The limit covers the clearing pass after reset, every clear in
  // the random part and the slowest adds under the heaviest stalls, many times.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: empty lists, a list filled to the brim, overflow on the
  // first and on a later edge, repeated edges in a full list, self edges, the
  // highest vertex, every slot boundary, the unused code and a clear that must
  // hide stale neighbours.
  task automatic test_directed_edges();
    send_word(make_word(FUNC_READ, 0, 0, 0, 0));
    send_word(make_word(FUNC_ADD, 0, 1, 2, 0));
    send_word(make_word(FUNC_ADD, 2, 1, 0, 0));       // same edges, reversed
    send_word(make_word(FUNC_ADD, 0, 3, 4, 0));
    send_word(make_word(FUNC_ADD, 0, 5, 6, 0));
    send_word(make_word(FUNC_ADD, 0, 7, 8, 0));       // vertex 0 is now full
    send_word(make_word(FUNC_ADD, 9, 0, 10, 0));      // overflow on the first edge
    send_word(make_word(FUNC_ADD, 0, 1, 2, 0));       // hits in a full list
    send_word(make_word(FUNC_READ, 0, 0, 0, 7));
    send_word(make_word(FUNC_READ, 0, 0, 0, 3));
    send_word(make_word(FUNC_ADD, 1023, 1023, 1023, 0));
    send_word(make_word(FUNC_READ, 1023, 0, 0, 0));
    send_word(make_word(FUNC_READ, 1023, 0, 0, 1));
    send_word(make_word(FUNC_ADD, 1022, 1023, 0, 0)); // overflow on the edge (1022,0)
    send_word(make_word(FUNC_UNUSED, 0, 1023, 1023, 7));
    send_word(make_word(FUNC_UNUSED, 1023, 0, 0, 0));
    send_word(make_word(FUNC_READ, 1022, 0, 0, 0));
    send_word(make_word(FUNC_READ, 682, 341, 682, 5));
    send_word(make_word(FUNC_ADD, 341, 682, 341, 2));
    send_word(make_word(FUNC_CLEAR, 0, 0, 0, 0));
    send_word(make_word(FUNC_READ, 0, 0, 0, 0));
    send_word(make_word(FUNC_ADD, 0, 2, 1, 0));
    send_word(make_word(FUNC_READ, 0, 0, 0, 1));
  endtask

  task automatic test_random_mesh(input int unsigned src_pct,
                                  input int unsigned snk_pct,
                                  input int unsigned words);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (words) send_word(random_mesh_word());
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // output register fills, the sequencer holds its finished word and the
  // input channel has to stall.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = HOLDOFF_CYCLES;
    repeat (25) send_word(random_mesh_word());
  endtask

  // The sender goes quiet until every reply is in, then resumes.
  task automatic test_drain_and_resume();
    drain_replies();
    src_idle_pct = 0;
    repeat (10) send_word(random_mesh_word());
  endtask

  initial begin
    mismatches   = 0;
    cycle_count  = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 0;
    pool_base    = 0;
    pool_life    = 0;
    foreach (adj_len[v]) adj_len[v] = '0;
    foreach (adj_nbr[v, s]) adj_nbr[v][s] = '0;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_CLEAR;
    in_if.vert_a    <= '0;
    in_if.vert_b    <= '0;
    in_if.vert_c    <= '0;
    in_if.read_slot <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_random_mesh(8, 55, 290);
    test_output_backpressure();
    test_random_mesh(55, 8, 290);
    test_drain_and_resume();
    test_random_mesh(0, 0, 290);

    // Let every owed reply arrive, then keep the clock running so that any stray
    // result word would show up.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/meab_pkg.sv
src/meab_if.sv
src/meab_lists.sv
src/mesh_edge_adjacency_builder.sv
dv/tb.sv
